// ===== src/dst_pkg.sv =====
// Package for the descriptor slot table: sizes, codes, item and command types.
// Used by every module of the block but dst_ram; depends on nothing.
`default_nettype none

package dst_pkg;

    // Table geometry
    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int HINT_W      = $clog2(SLOTS + 1);

    // Fixed field widths of the item interface
    localparam int DESC_W  = 7;
    localparam int ECHO_W  = 6;
    localparam int FOUND_W = 32;

    // Depth of the small queues (power of two)
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSTALL = 2'd0,
        OP_GET     = 2'd1,
        OP_CLOSE   = 2'd2,
        OP_RSVD    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DESC = 2'd1,
        ST_FULL     = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    // Work kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_INSTALL,
        CMD_GET,
        CMD_CLOSE,
        CMD_REJECT
    } t_cmd_kind;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } t_bk_state;

    typedef struct packed {
        t_op                    op;
        logic [DESC_W-1:0]      descriptor;
        logic [HANDLE_BITS-1:0] handle;
        logic                   close_on_exec;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [ECHO_W-1:0]  slot_number;
        logic [FOUND_W-1:0] found_handle;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind              kind;
        t_status                rej_status;
        logic [SLOT_W-1:0]      slot;
        logic [ECHO_W-1:0]      echo;
        logic [HANDLE_BITS-1:0] handle;
        logic                   cloexec;
    } t_cmd;

    // One row of the handle memory
    typedef struct packed {
        logic                   cloexec;
        logic [HANDLE_BITS-1:0] handle;
    } t_slot_word;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_find;

    // Lowest set bit of a slot vector
    function automatic t_find lowest_set(logic [SLOTS-1:0] v);
        t_find res;
        res = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res.found = 1'b1;
                res.idx   = SLOT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/descriptor_slot_table.sv =====
// Top level of the descriptor slot table: front end, back end, queues between.
// Depends on dst_pkg, dst_front, dst_back (and dst_ram through dst_back).
//
//   channel   | valid/ready     | payload
//   ----------+-----------------+-------------------------
//   input     | push / full     | i_item   (t_in_item)
//   result    | empty / pop     | o_result (t_out_item)
//
// The front decodes an item in the cycle it is taken and queues it (two entries).
// Install and rejected items finish in the back end's idle state; get and close
// go on to a read state, set by the registered read of the handle memory. A result is visible the
// cycle after the back end finishes it and waits in a two-entry queue.
// Reset clears the occupancy bits and the hint directly; no clearing pass.
// A full result queue stalls the back end; a full command queue raises full.
`default_nettype none

module descriptor_slot_table
    import dst_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output      logic      full,
    input  wire t_in_item  i_item,
    output      logic      empty,
    input  wire logic      pop,
    output      t_out_item o_result
);

    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;

    dst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty),
        .i_cmd_pop   (cmd_pop)
    );

    dst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

`default_nettype wire

// ===== src/dst_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none

module dst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/dst_front.sv =====
// Front end: accepts items, decodes and range-checks them, queues commands.
// Depends on dst_pkg.
`default_nettype none

module dst_front
    import dst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output      logic     full,
    input  wire t_in_item i_item,
    output      t_cmd     o_cmd,
    output      logic     o_cmd_empty,
    input  wire logic     i_cmd_pop
);

    t_cmd              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    t_cmd cmd;
    logic in_range;
    logic take;
    logic give;

    // Classify the incoming item
    always_comb begin
        in_range    = 32'(i_item.descriptor) < 32'(SLOTS);
        cmd         = '0;
        cmd.slot    = SLOT_W'(i_item.descriptor);
        cmd.echo    = i_item.descriptor[ECHO_W-1:0];
        cmd.handle  = i_item.handle;
        cmd.cloexec = i_item.close_on_exec;
        case (i_item.op)
            OP_INSTALL: begin
                cmd.echo = '0;
                if (i_item.handle == '0) begin
                    cmd.kind       = CMD_REJECT;
                    cmd.rej_status = ST_INVALID;
                end else begin
                    cmd.kind = CMD_INSTALL;
                end
            end
            OP_GET, OP_CLOSE: begin
                if (!in_range) begin
                    cmd.kind       = CMD_REJECT;
                    cmd.rej_status = ST_BAD_DESC;
                end else begin
                    cmd.kind = (i_item.op == OP_GET) ? CMD_GET : CMD_CLOSE;
                end
            end
            default: begin
                cmd.echo       = '0;
                cmd.kind       = CMD_REJECT;
                cmd.rej_status = ST_INVALID;
            end
        endcase
    end

    // Command queue toward the back end
    assign full        = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_cmd_empty = (r_cnt == '0);
    assign o_cmd       = r_q[r_rd];
    assign take        = push && !full;
    assign give        = i_cmd_pop && !o_cmd_empty;

    always_comb begin
        n_wr  = take ? r_wr + 1'b1 : r_wr;
        n_rd  = give ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(take) - QCNT_W'(give);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wr] <= cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/dst_back.sv =====
// Back end: occupancy bits, next-free hint, handle memory and result queue.
// Depends on dst_pkg and dst_ram.
`default_nettype none

module dst_back
    import dst_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_cmd_empty,
    output      logic      o_cmd_pop,
    output      t_out_item o_result,
    output      logic      empty,
    input  wire logic      pop
);

    t_bk_state         r_state, n_state;
    t_cmd              r_cur, n_cur;
    logic [SLOTS-1:0]  r_occ, n_occ;
    logic [HINT_W-1:0] r_hint, n_hint;

    t_out_item         r_rq [Q_DEPTH];
    logic [QPTR_W-1:0] r_rwr;
    logic [QPTR_W-1:0] r_rrd;
    logic [QCNT_W-1:0] r_rcnt;

    logic [SLOTS-1:0]       above;
    t_find                  hit_hi;
    t_find                  hit_lo;
    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    t_slot_word             ram_wdata;
    t_slot_word             ram_rdata;
    logic [HANDLE_BITS-1:0] stored;
    logic                   res_full;
    logic                   res_push;
    logic                   res_give;
    t_out_item              res_data;

    dst_ram #(
        .WIDTH ($bits(t_slot_word)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_cmd.slot),
        .o_rdata (ram_rdata)
    );

    // Free-slot search: upward from the hint first, then from zero
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            above[i] = HINT_W'(i) >= r_hint;
        end
        hit_hi = lowest_set(~r_occ & above);
        hit_lo = lowest_set(~r_occ);
    end

    assign res_full = (r_rcnt == QCNT_W'(Q_DEPTH));
    assign stored   = r_occ[r_cur.slot] ? ram_rdata.handle : '0;

    // Sequencer: install and rejects finish at once, get and close read first
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_occ     = r_occ;
        n_hint    = r_hint;
        o_cmd_pop = 1'b0;
        res_push  = 1'b0;
        res_data  = '0;
        ram_we    = 1'b0;
        ram_waddr = hit_hi.found ? hit_hi.idx : hit_lo.idx;
        ram_wdata = '{cloexec: i_cmd.cloexec, handle: i_cmd.handle};
        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty && !res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_INSTALL: begin
                            res_push = 1'b1;
                            if (hit_lo.found) begin
                                ram_we               = 1'b1;
                                n_occ[ram_waddr]     = 1'b1;
                                res_data.status      = ST_OK;
                                res_data.slot_number = ECHO_W'(ram_waddr);
                                if (hit_hi.found) begin
                                    n_hint = HINT_W'(hit_hi.idx) + 1'b1;
                                end
                            end else begin
                                res_data.status = ST_FULL;
                            end
                        end
                        CMD_GET, CMD_CLOSE: begin
                            n_cur   = i_cmd;
                            n_state = BK_READ;
                        end
                        default: begin
                            res_push             = 1'b1;
                            res_data.status      = i_cmd.rej_status;
                            res_data.slot_number = i_cmd.echo;
                        end
                    endcase
                end
            end
            BK_READ: begin
                res_push             = 1'b1;
                res_data.slot_number = r_cur.echo;
                res_data.status      = ST_BAD_DESC;
                n_state              = BK_IDLE;
                if (r_cur.kind == CMD_GET) begin
                    if (r_occ[r_cur.slot]) begin
                        res_data.status       = ST_OK;
                        res_data.found_handle = FOUND_W'(stored);
                    end
                end else if (stored == r_cur.handle) begin
                    // a zero handle on an empty slot still lowers the hint
                    n_occ[r_cur.slot] = 1'b0;
                    if (HINT_W'(r_cur.slot) < r_hint) begin
                        n_hint = HINT_W'(r_cur.slot);
                    end
                    if (r_cur.handle != '0) begin
                        res_data.status = ST_OK;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_occ   <= '0;
            r_hint  <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_hint  <= n_hint;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    // Result queue
    assign empty    = (r_rcnt == '0);
    assign o_result = r_rq[r_rrd];
    assign res_give = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwr  <= '0;
            r_rrd  <= '0;
            r_rcnt <= '0;
        end else begin
            if (res_push) begin
                r_rwr <= r_rwr + 1'b1;
            end
            if (res_give) begin
                r_rrd <= r_rrd + 1'b1;
            end
            r_rcnt <= r_rcnt + QCNT_W'(res_push) - QCNT_W'(res_give);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_rq[r_rwr] <= res_data;
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for descriptor_slot_table: install, get and close items
// against a cycle-free model of the slot table. Depends on dst_pkg and the block.
`timescale 1ns / 1ps

module testbench;
    import dst_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int EPOCH_LEN    = 150;

    // Random phase shapes
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_item  i_item  = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    descriptor_slot_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Table image, updated as items are accepted
    logic [HANDLE_BITS-1:0] tbl_handle [SLOTS];
    logic                   tbl_cloexec [SLOTS];
    logic [HINT_W-1:0]      tbl_hint;

    t_in_item  pending_items [$];
    t_out_item replies_due [$];
    int        fail_count    = 0;
    int        send_gap      = 0;
    int        recv_gap      = 0;
    logic      quiet_stretch = 1'b0;

    // Apply one item to the table image and return the reply it must produce
    function automatic t_out_item apply_table_op(t_in_item it);
        t_out_item rep;
        logic      hit;
        int        sidx;
        int        d;
        rep  = '0;
        hit  = 1'b0;
        sidx = 0;
        d    = int'(it.descriptor);
        case (it.op)
            OP_INSTALL: begin
                if (it.handle == '0) begin
                    rep.status = ST_INVALID;
                end else begin
                    // upward from the hint first, then wrap below it
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!hit && i >= int'(tbl_hint) && tbl_handle[i] == '0) begin
                            hit  = 1'b1;
                            sidx = i;
                        end
                    end
                    if (hit) begin
                        tbl_hint = HINT_W'(sidx + 1);
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!hit && i < int'(tbl_hint) && tbl_handle[i] == '0) begin
                                hit  = 1'b1;
                                sidx = i;
                            end
                        end
                    end
                    if (hit) begin
                        tbl_handle[sidx]  = it.handle;
                        tbl_cloexec[sidx] = it.close_on_exec;
                        rep.status        = ST_OK;
                        rep.slot_number   = ECHO_W'(sidx);
                    end else begin
                        rep.status = ST_FULL;
                    end
                end
            end
            OP_GET: begin
                rep.slot_number = it.descriptor[ECHO_W-1:0];
                if (d >= SLOTS || tbl_handle[d] == '0) begin
                    rep.status = ST_BAD_DESC;
                end else begin
                    rep.status       = ST_OK;
                    rep.found_handle = tbl_handle[d];
                end
            end
            OP_CLOSE: begin
                rep.slot_number = it.descriptor[ECHO_W-1:0];
                if (d >= SLOTS || tbl_handle[d] != it.handle) begin
                    rep.status = ST_BAD_DESC;
                end else begin
                    // zero handle on an empty slot still clears and lowers the hint
                    tbl_handle[d]  = '0;
                    tbl_cloexec[d] = 1'b0;
                    if (d < int'(tbl_hint)) begin
                        tbl_hint = HINT_W'(d);
                    end
                    rep.status = (it.handle == '0) ? ST_BAD_DESC : ST_OK;
                end
            end
            default: begin
                rep.status = ST_INVALID;
            end
        endcase
        return rep;
    endfunction

    function automatic t_in_item mk_item(t_op op, int desc, logic [HANDLE_BITS-1:0] h,
                                         logic cx);
        t_in_item it;
        it.op            = op;
        it.descriptor    = desc[DESC_W-1:0];
        it.handle        = h;
        it.close_on_exec = cx;
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random occupied slot, or -1 when the table is empty
    function automatic int pick_occupied();
        int cands [$];
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_handle[i] != '0) begin
                cands.push_back(i);
            end
        end
        if (cands.size() == 0) begin
            return -1;
        end
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    function automatic logic [HANDLE_BITS-1:0] rand_handle();
        int r;
        int occ;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end else if (r == 2) begin
            return HANDLE_BITS'($urandom_range(1, 15));
        end else if (r < 5) begin
            // duplicate of a handle already installed
            occ = pick_occupied();
            if (occ >= 0) begin
                return tbl_handle[occ];
            end
        end
        return HANDLE_BITS'($urandom);
    endfunction

    function automatic t_in_item close_item(int pct_good);
        int occ;
        occ = pick_occupied();
        if (occ >= 0 && $urandom_range(0, 99) < pct_good) begin
            return mk_item(OP_CLOSE, occ, tbl_handle[occ], 1'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            return mk_item(OP_CLOSE, $urandom_range(0, 127), '0, 1'($urandom));
        end
        return mk_item(OP_CLOSE, $urandom_range(0, 127), rand_handle(), 1'($urandom));
    endfunction

    function automatic t_in_item get_item();
        int occ;
        occ = pick_occupied();
        if (occ >= 0 && $urandom_range(0, 1) == 0) begin
            return mk_item(OP_GET, occ, HANDLE_BITS'($urandom), 1'($urandom));
        end
        return mk_item(OP_GET, $urandom_range(0, 127), HANDLE_BITS'($urandom),
                       1'($urandom));
    endfunction

    function automatic t_in_item random_item(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 85) begin
                    return mk_item(OP_INSTALL, $urandom_range(0, 127), rand_handle(),
                                   1'($urandom));
                end else if (r < 95) begin
                    return get_item();
                end
                return close_item(80);
            end
            MODE_DRAIN: begin
                if (r < 70) begin
                    return close_item(90);
                end else if (r < 85) begin
                    return get_item();
                end
                return mk_item(OP_INSTALL, $urandom_range(0, 127), rand_handle(),
                               1'($urandom));
            end
            default: begin
                if (r < 5) begin
                    return mk_item(OP_RSVD, $urandom_range(0, 127), HANDLE_BITS'($urandom),
                                   1'($urandom));
                end else if (r < 37) begin
                    return mk_item(OP_INSTALL, $urandom_range(0, 127), rand_handle(),
                                   1'($urandom));
                end else if (r < 68) begin
                    return get_item();
                end
                return close_item(50);
            end
        endcase
    endfunction

    // Driver: present the next pending item, hold it until taken, then maybe idle
    always @(posedge i_clk) begin
        t_in_item nxt_item;
        logic     nxt_push;
        nxt_item = i_item;
        nxt_push = push;
        if (i_rst_n) begin
            if (push && !full) begin
                replies_due.push_back(apply_table_op(i_item));
                nxt_push = 1'b0;
                send_gap = pick_gap();
            end
            if (!nxt_push) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    nxt_item = pending_items.pop_front();
                    nxt_push = 1'b1;
                end
            end
        end
        i_item <= nxt_item;
        push   <= nxt_push;
    end

    // Monitor: take replies with random stalls and check them in order
    always @(posedge i_clk) begin
        t_out_item want;
        logic      nxt_pop;
        nxt_pop = pop;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: status %0d slot %0d handle %h",
                           o_result.status, o_result.slot_number, o_result.found_handle);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        fail_count++;
                    end
                    if (o_result.slot_number !== want.slot_number) begin
                        $error("slot_number: expected %0d, got %0d",
                               want.slot_number, o_result.slot_number);
                        fail_count++;
                    end
                    if (o_result.found_handle !== want.found_handle) begin
                        $error("found_handle: expected %h, got %h",
                               want.found_handle, o_result.found_handle);
                        fail_count++;
                    end
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                nxt_pop = 1'b0;
            end else begin
                nxt_pop = 1'b1;
            end
        end
        pop <= nxt_pop;
    end

    // Stimulus and end of run
    initial begin
        int mode;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_handle[i]  = '0;
            tbl_cloexec[i] = 1'b0;
        end
        tbl_hint = '0;
        mode     = MODE_MIX;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, zero handles, duplicates, out-of-range, reserved op
        pending_items.push_back(mk_item(OP_GET,     0,   '0,            1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   0,   '0,            1'b0));
        pending_items.push_back(mk_item(OP_INSTALL, 0,   '0,            1'b1));
        pending_items.push_back(mk_item(OP_INSTALL, 127, '1,            1'b1));
        pending_items.push_back(mk_item(OP_INSTALL, 0,   32'h1,         1'b0));
        pending_items.push_back(mk_item(OP_INSTALL, 5,   '1,            1'b0));
        pending_items.push_back(mk_item(OP_GET,     0,   '1,            1'b1));
        pending_items.push_back(mk_item(OP_GET,     127, '0,            1'b0));
        pending_items.push_back(mk_item(OP_GET,     64,  '0,            1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   1,   32'h2,         1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   1,   32'h1,         1'b1));
        pending_items.push_back(mk_item(OP_INSTALL, 0,   32'hA5A5_5A5A, 1'b1));
        pending_items.push_back(mk_item(OP_GET,     1,   '0,            1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   127, '0,            1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   64,  '1,            1'b1));
        pending_items.push_back(mk_item(OP_RSVD,    127, '1,            1'b1));
        pending_items.push_back(mk_item(OP_RSVD,    0,   '0,            1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   0,   '1,            1'b0));
        pending_items.push_back(mk_item(OP_GET,     0,   '0,            1'b0));
        pending_items.push_back(mk_item(OP_INSTALL, 0,   32'h8000_0000, 1'b0));
        pending_items.push_back(mk_item(OP_GET,     63,  '0,            1'b0));
        pending_items.push_back(mk_item(OP_CLOSE,   63,  '0,            1'b1));
        pending_items.push_back(mk_item(OP_CLOSE,   2,   '1,            1'b0));
        pending_items.push_back(mk_item(OP_INSTALL, 0,   32'h5A5A_A5A5, 1'b1));

        // random phases: fill to full, drain, and mixed traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            while (pending_items.size() >= 2) @(negedge i_clk);
            if (n % EPOCH_LEN == 0) begin
                mode          = $urandom_range(MODE_FILL, MODE_MIX);
                quiet_stretch = ($urandom_range(0, 3) == 0);
            end
            pending_items.push_back(random_item(mode));
        end

        // wait on the falling edge so driver and monitor updates have settled
        while (pending_items.size() != 0 || push || replies_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
